// ===== rtl/eik_pkg.sv =====
// Shared types and constants for the eikonal cell update pipeline.
// No dependencies; every other file in rtl uses this package by scoped names.
package eik_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int SPACING_WIDTH = 31;

    localparam int DIFF_WIDTH = VALUE_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * SPACING_WIDTH;
    localparam int RAD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int ROOT_WIDTH = RAD_WIDTH / 2;
    localparam int REM_WIDTH  = ROOT_WIDTH + 4;
    localparam int SUM_WIDTH  = VALUE_WIDTH + 2;

    // Square root retires SQRT_STEPS result bits in each of SQRT_STAGES stages.
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_WIDTH / SQRT_STEPS;

    localparam int FRONT_STAGES = 2;
    localparam int RAD_STAGES   = 2;
    localparam int BACK_STAGES  = 3;
    localparam int NUM_STAGES   = FRONT_STAGES + RAD_STAGES + SQRT_STAGES + BACK_STAGES;

    localparam int FRONT_BASE = 0;
    localparam int RAD_BASE   = FRONT_BASE + FRONT_STAGES;
    localparam int SQRT_BASE  = RAD_BASE + RAD_STAGES;
    localparam int BACK_BASE  = SQRT_BASE + SQRT_STAGES;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [SPACING_WIDTH-1:0]      t_spacing;

    localparam t_spacing SPACING_RESET = t_spacing'(64'd1 << FRACTION_BITS);

    // Per-item sideband that rides along the square root.
    typedef struct packed {
        t_value   center;
        t_value   base;     // a1 for a positive cell, a2 otherwise
        t_spacing diff;     // a2 - a1, meaningful when quad is set
        logic     pos;
        logic     fixed;
        logic     quad;
    } t_side;

endpackage

// ===== rtl/eikonal_sweep_cell_update.sv =====
// Top level of the fast-sweeping eikonal cell update: config register,
// pipeline valid and stall control, and the four datapath sections.
// Depends on eik_pkg, eik_front, eik_radicand, eik_sqrt and eik_back.
//
//   Channel  | Direction | Handshake                    | Payload
//   ---------+-----------+------------------------------+-----------------------------
//   in       | input     | i_in_valid / o_in_stall      | center, west, east, south,
//            |           |                              | north values, is_fixed
//   out      | output    | o_out_valid / i_out_stall    | o_new_value
//   cfg      | input     | i_cfg_valid / o_cfg_ready    | i_cfg_data (grid spacing)
//
// One item per cycle is accepted while no stall holds the input; each item passes 23
// register stages, most of them the 16 stages of the two-bits-per-stage square root.
// Synchronous active-low reset clears the valid bits and sets the spacing to 1.0.
// A stall holds only the stages that are full behind it; empty stages keep filling.
// The config port is always ready.
module eikonal_sweep_cell_update (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  eik_pkg::t_value        i_center_value,
    input  eik_pkg::t_value        i_west_value,
    input  eik_pkg::t_value        i_east_value,
    input  eik_pkg::t_value        i_south_value,
    input  eik_pkg::t_value        i_north_value,
    input  logic                   i_is_fixed,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output eik_pkg::t_value        o_new_value,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  eik_pkg::t_spacing      i_cfg_data
);

    eik_pkg::t_spacing                     r_grid_spacing;
    logic [eik_pkg::NUM_STAGES-1:0]        r_vld;
    logic [eik_pkg::NUM_STAGES-1:0]        n_vld;
    logic [eik_pkg::NUM_STAGES-1:0]        w_en;
    logic                                  w_acc;
    logic                                  w_dlv;

    eik_pkg::t_side                        w_side_front;
    eik_pkg::t_side                        w_side_rad;
    eik_pkg::t_side                        w_side_sq;
    logic [eik_pkg::RAD_WIDTH-1:0]         w_rad;
    logic [eik_pkg::ROOT_WIDTH-1:0]        w_root;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_spacing <= eik_pkg::SPACING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_spacing <= i_cfg_data;
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    assign w_en  = ~r_vld | {~i_out_stall, w_en[eik_pkg::NUM_STAGES-1:1]};
    assign n_vld = {r_vld[eik_pkg::NUM_STAGES-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (n_vld & w_en) | (r_vld & ~w_en);
        end
    end

    assign o_in_stall  = ~w_en[0];
    assign o_out_valid = r_vld[eik_pkg::NUM_STAGES-1];
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_dlv       = o_out_valid && !i_out_stall;

    eik_front u_front (
        .i_clk          (i_clk),
        .i_en           (w_en[eik_pkg::FRONT_BASE +: eik_pkg::FRONT_STAGES]),
        .i_center_value (i_center_value),
        .i_west_value   (i_west_value),
        .i_east_value   (i_east_value),
        .i_south_value  (i_south_value),
        .i_north_value  (i_north_value),
        .i_is_fixed     (i_is_fixed),
        .i_spacing      (r_grid_spacing),
        .o_side         (w_side_front)
    );

    eik_radicand u_radicand (
        .i_clk     (i_clk),
        .i_en      (w_en[eik_pkg::RAD_BASE +: eik_pkg::RAD_STAGES]),
        .i_side    (w_side_front),
        .i_spacing (r_grid_spacing),
        .o_rad     (w_rad),
        .o_side    (w_side_rad)
    );

    eik_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[eik_pkg::SQRT_BASE +: eik_pkg::SQRT_STAGES]),
        .i_rad  (w_rad),
        .i_side (w_side_rad),
        .o_root (w_root),
        .o_side (w_side_sq)
    );

    eik_back u_back (
        .i_clk       (i_clk),
        .i_en        (w_en[eik_pkg::BACK_BASE +: eik_pkg::BACK_STAGES]),
        .i_root      (w_root),
        .i_side      (w_side_sq),
        .i_spacing   (r_grid_spacing),
        .o_new_value (o_new_value)
    );

`ifndef SYNTH
    // Input is held off only when every stage is full and the output is blocked.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld) && i_out_stall)
        else $error("input stalled while the pipeline has room");

    // Items in flight change only by what was accepted and delivered.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) + int'($past(w_dlv))) ==
            ($past($countones(r_vld)) + int'($past(w_acc))))
        else $error("pipeline lost or duplicated an item");

    // On the quadratic path the root exceeds the difference, since 2h^2 - d^2 > h^2.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[eik_pkg::BACK_BASE-1] && w_side_sq.quad) |->
            (w_root > eik_pkg::ROOT_WIDTH'(w_side_sq.diff)))
        else $error("square root below the axis difference");
`endif

endmodule

// ===== rtl/eik_front.sv =====
// Front end: axis minima or maxima, sort, difference and form select (two stages).
// Depends on eik_pkg.
module eik_front (
    input  logic                                i_clk,
    input  logic [eik_pkg::FRONT_STAGES-1:0]    i_en,
    input  eik_pkg::t_value                     i_center_value,
    input  eik_pkg::t_value                     i_west_value,
    input  eik_pkg::t_value                     i_east_value,
    input  eik_pkg::t_value                     i_south_value,
    input  eik_pkg::t_value                     i_north_value,
    input  logic                                i_is_fixed,
    input  eik_pkg::t_spacing                   i_spacing,
    output eik_pkg::t_side                      o_side
);

    eik_pkg::t_value w_a;
    eik_pkg::t_value w_b;
    logic            w_pos;

    eik_pkg::t_value r_center;
    eik_pkg::t_value r_a1;
    eik_pkg::t_value r_a2;
    logic            r_pos;
    logic            r_fixed;

    logic [eik_pkg::DIFF_WIDTH-1:0] w_diff;
    eik_pkg::t_side                 r_side;

    always_comb begin
        w_pos = (i_center_value > eik_pkg::t_value'(0));
        if (w_pos) begin
            w_a = (i_west_value < i_east_value) ? i_west_value : i_east_value;
            w_b = (i_south_value < i_north_value) ? i_south_value : i_north_value;
        end else begin
            w_a = (i_west_value > i_east_value) ? i_west_value : i_east_value;
            w_b = (i_south_value > i_north_value) ? i_south_value : i_north_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_center <= i_center_value;
            r_a1     <= (w_a < w_b) ? w_a : w_b;
            r_a2     <= (w_a < w_b) ? w_b : w_a;
            r_pos    <= w_pos;
            r_fixed  <= i_is_fixed;
        end
    end

    // The sorted difference is never negative, so it is read as unsigned.
    assign w_diff = {r_a2[eik_pkg::VALUE_WIDTH-1], r_a2} - {r_a1[eik_pkg::VALUE_WIDTH-1], r_a1};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side.center <= r_center;
            r_side.base   <= r_pos ? r_a1 : r_a2;
            r_side.diff   <= w_diff[eik_pkg::SPACING_WIDTH-1:0];
            r_side.pos    <= r_pos;
            r_side.fixed  <= r_fixed;
            r_side.quad   <= (w_diff < eik_pkg::DIFF_WIDTH'(i_spacing));
        end
    end

    assign o_side = r_side;

endmodule

// ===== rtl/eik_radicand.sv =====
// Radicand 2*h*h - d*d: squares in one stage, subtraction in the next.
// Depends on eik_pkg.
module eik_radicand (
    input  logic                              i_clk,
    input  logic [eik_pkg::RAD_STAGES-1:0]    i_en,
    input  eik_pkg::t_side                    i_side,
    input  eik_pkg::t_spacing                 i_spacing,
    output logic [eik_pkg::RAD_WIDTH-1:0]     o_rad,
    output eik_pkg::t_side                    o_side
);

    logic [eik_pkg::PROD_WIDTH-1:0] w_hh;
    logic [eik_pkg::PROD_WIDTH-1:0] w_dd;
    logic [eik_pkg::PROD_WIDTH-1:0] r_hh;
    logic [eik_pkg::PROD_WIDTH-1:0] r_dd;
    eik_pkg::t_side                 r_side_mul;
    logic [eik_pkg::RAD_WIDTH-1:0]  r_rad;
    eik_pkg::t_side                 r_side_rad;

    assign w_hh = eik_pkg::PROD_WIDTH'(i_spacing) * eik_pkg::PROD_WIDTH'(i_spacing);
    assign w_dd = eik_pkg::PROD_WIDTH'(i_side.diff) * eik_pkg::PROD_WIDTH'(i_side.diff);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hh       <= w_hh;
            r_dd       <= w_dd;
            r_side_mul <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rad      <= {1'b0, r_hh, 1'b0} - {2'b00, r_dd};
            r_side_rad <= r_side_mul;
        end
    end

    assign o_rad  = r_rad;
    assign o_side = r_side_rad;

endmodule

// ===== rtl/eik_sqrt.sv =====
// Pipelined restoring integer square root, two root bits per stage.
// Depends on eik_pkg; carries the item sideband alongside.
module eik_sqrt (
    input  logic                              i_clk,
    input  logic [eik_pkg::SQRT_STAGES-1:0]   i_en,
    input  logic [eik_pkg::RAD_WIDTH-1:0]     i_rad,
    input  eik_pkg::t_side                    i_side,
    output logic [eik_pkg::ROOT_WIDTH-1:0]    o_root,
    output eik_pkg::t_side                    o_side
);

    logic [eik_pkg::REM_WIDTH-1:0]  w_rem_in  [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::ROOT_WIDTH-1:0] w_root_in [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::RAD_WIDTH-1:0]  w_rad_in  [eik_pkg::SQRT_STAGES];
    eik_pkg::t_side                 w_side_in [eik_pkg::SQRT_STAGES];

    logic [eik_pkg::REM_WIDTH-1:0]  w_rem_nx  [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::ROOT_WIDTH-1:0] w_root_nx [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::RAD_WIDTH-1:0]  w_rad_nx  [eik_pkg::SQRT_STAGES];

    logic [eik_pkg::REM_WIDTH-1:0]  r_rem  [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::ROOT_WIDTH-1:0] r_root [eik_pkg::SQRT_STAGES];
    logic [eik_pkg::RAD_WIDTH-1:0]  r_rad  [eik_pkg::SQRT_STAGES];
    eik_pkg::t_side                 r_side [eik_pkg::SQRT_STAGES];

    for (genvar g = 0; g < eik_pkg::SQRT_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_rem_in[g]  = '0;
            assign w_root_in[g] = '0;
            assign w_rad_in[g]  = i_rad;
            assign w_side_in[g] = i_side;
        end else begin : g_rest
            assign w_rem_in[g]  = r_rem[g-1];
            assign w_root_in[g] = r_root[g-1];
            assign w_rad_in[g]  = r_rad[g-1];
            assign w_side_in[g] = r_side[g-1];
        end

        // Each step brings down the next bit pair and tries 4*root + 1.
        always_comb begin : p_steps
            logic [eik_pkg::REM_WIDTH-1:0]  rem;
            logic [eik_pkg::ROOT_WIDTH-1:0] root;
            logic [eik_pkg::RAD_WIDTH-1:0]  rad;
            logic [eik_pkg::REM_WIDTH-1:0]  trial;
            rem  = w_rem_in[g];
            root = w_root_in[g];
            rad  = w_rad_in[g];
            for (int s = 0; s < eik_pkg::SQRT_STEPS; s++) begin
                rem   = {rem[eik_pkg::REM_WIDTH-3:0], rad[eik_pkg::RAD_WIDTH-1 -: 2]};
                rad   = {rad[eik_pkg::RAD_WIDTH-3:0], 2'b00};
                trial = eik_pkg::REM_WIDTH'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[eik_pkg::ROOT_WIDTH-2:0], 1'b1};
                end else begin
                    root = {root[eik_pkg::ROOT_WIDTH-2:0], 1'b0};
                end
            end
            w_rem_nx[g]  = rem;
            w_root_nx[g] = root;
            w_rad_nx[g]  = rad;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g]) begin
                r_rem[g]  <= w_rem_nx[g];
                r_root[g] <= w_root_nx[g];
                r_rad[g]  <= w_rad_nx[g];
                r_side[g] <= w_side_in[g];
            end
        end
    end

    assign o_root = r_root[eik_pkg::SQRT_STAGES-1];
    assign o_side = r_side[eik_pkg::SQRT_STAGES-1];

endmodule

// ===== rtl/eik_back.sv =====
// Back end: half of (d + root) on the quadratic form, else the spacing, saturating update,
// min or max against the old value and fixed-cell bypass (three stages). Depends on eik_pkg.
module eik_back (
    input  logic                              i_clk,
    input  logic [eik_pkg::BACK_STAGES-1:0]   i_en,
    input  logic [eik_pkg::ROOT_WIDTH-1:0]    i_root,
    input  eik_pkg::t_side                    i_side,
    input  eik_pkg::t_spacing                 i_spacing,
    output eik_pkg::t_value                   o_new_value
);

    localparam logic signed [eik_pkg::SUM_WIDTH-1:0] SumMax =
        eik_pkg::SUM_WIDTH'({1'b0, {(eik_pkg::VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [eik_pkg::SUM_WIDTH-1:0] SumMin = -SumMax - 1;

    logic [eik_pkg::ROOT_WIDTH:0]              w_half_sum;
    logic [eik_pkg::ROOT_WIDTH-1:0]            r_step;
    eik_pkg::t_side                            r_side_step;
    logic signed [eik_pkg::SUM_WIDTH-1:0]      w_base;
    logic signed [eik_pkg::SUM_WIDTH-1:0]      w_step;
    logic signed [eik_pkg::SUM_WIDTH-1:0]      w_sum;
    eik_pkg::t_value                           w_sat;
    eik_pkg::t_value                           r_upd;
    eik_pkg::t_side                            r_side_upd;
    eik_pkg::t_value                           w_res;
    eik_pkg::t_value                           r_out;

    assign w_half_sum = eik_pkg::ROOT_WIDTH'(i_side.diff) + (eik_pkg::ROOT_WIDTH + 1)'(i_root);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_step      <= i_side.quad ? w_half_sum[eik_pkg::ROOT_WIDTH:1]
                                       : eik_pkg::ROOT_WIDTH'(i_spacing);
            r_side_step <= i_side;
        end
    end

    always_comb begin
        w_base = eik_pkg::SUM_WIDTH'(r_side_step.base);
        w_step = $signed(eik_pkg::SUM_WIDTH'(r_step));
        w_sum  = r_side_step.pos ? (w_base + w_step) : (w_base - w_step);
        priority if (w_sum > SumMax) begin
            w_sat = eik_pkg::VALUE_WIDTH'(SumMax);
        end else if (w_sum < SumMin) begin
            w_sat = eik_pkg::VALUE_WIDTH'(SumMin);
        end else begin
            w_sat = eik_pkg::VALUE_WIDTH'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_upd      <= w_sat;
            r_side_upd <= r_side_step;
        end
    end

    always_comb begin
        if (r_side_upd.fixed) begin
            w_res = r_side_upd.center;
        end else if (r_side_upd.pos) begin
            w_res = (r_upd < r_side_upd.center) ? r_upd : r_side_upd.center;
        end else begin
            w_res = (r_upd > r_side_upd.center) ? r_upd : r_side_upd.center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_out <= w_res;
        end
    end

    assign o_new_value = r_out;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for eikonal_sweep_cell_update: streams grid cells under random idling and stalls
// and checks every new value against a Godunov upwind update predicted here.
// Depends on eik_pkg and the RTL top level eikonal_sweep_cell_update.
module testbench;

    typedef eik_pkg::t_value   t_value;
    typedef eik_pkg::t_spacing t_spacing;

    localparam int IDLE_LIMIT         = 4000;
    localparam int SETTLE_CYCLES      = 40;
    localparam int MAX_MISMATCH_LINES = 100;
    localparam int PHASE_ITEMS        = 170;

    localparam longint   VALUE_HI    = (longint'(1) <<< (eik_pkg::VALUE_WIDTH - 1)) - 1;
    localparam longint   VALUE_LO    = -VALUE_HI - 1;
    localparam t_value   VALUE_MAX   = t_value'(VALUE_HI);
    localparam t_value   VALUE_MIN   = t_value'(VALUE_LO);
    localparam t_value   ONE         = t_value'(longint'(1) <<< eik_pkg::FRACTION_BITS);
    localparam t_spacing SPACING_MAX = '1;

    typedef struct {
        t_value center;
        t_value west;
        t_value east;
        t_value south;
        t_value north;
        logic   fixed;
    } t_cell;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     in_valid     = 1'b0;
    logic     in_stall;
    t_value   center_value = '0;
    t_value   west_value   = '0;
    t_value   east_value   = '0;
    t_value   south_value  = '0;
    t_value   north_value  = '0;
    logic     is_fixed     = 1'b0;
    logic     out_valid;
    logic     out_stall    = 1'b0;
    t_value   new_value;
    logic     cfg_valid    = 1'b0;
    logic     cfg_ready;
    t_spacing cfg_data     = '0;

    t_spacing spacing_model = eik_pkg::SPACING_RESET;
    t_value   expected_values[$];
    t_value   want_value;
    int       error_count  = 0;
    int       stall_left   = 0;
    int       hold_left    = 0;
    int       hold_request = 0;
    int       idle_cycles  = 0;
    bit       send_idle    = 1'b1;
    bit       recv_idle    = 1'b1;

    eikonal_sweep_cell_update u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_center_value(center_value),
        .i_west_value  (west_value),
        .i_east_value  (east_value),
        .i_south_value (south_value),
        .i_north_value (north_value),
        .i_is_fixed    (is_fixed),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_new_value   (new_value),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint sat_value(longint x);
        if (x > VALUE_HI) return VALUE_HI;
        if (x < VALUE_LO) return VALUE_LO;
        return x;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned rad);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= rad) root = trial;
        end
        return root;
    endfunction

    function automatic t_value predict_new_value(t_cell c, t_spacing h);
        longint cv, ax, ay, a1, a2, step, upd, res;
        longint unsigned hh, d;
        if (c.fixed) return c.center;
        cv = c.center;
        hh = h;
        // Upwind neighbors: axis minima for a positive cell, maxima otherwise.
        if (cv > 0) begin
            ax = (c.west < c.east) ? c.west : c.east;
            ay = (c.south < c.north) ? c.south : c.north;
        end else begin
            ax = (c.west > c.east) ? c.west : c.east;
            ay = (c.south > c.north) ? c.south : c.north;
        end
        a1 = (ax < ay) ? ax : ay;
        a2 = (ax < ay) ? ay : ax;
        d = a2 - a1;
        if (d < hh) begin
            step = longint'((d + floor_sqrt(2 * hh * hh - d * d)) >> 1);
        end else begin
            step = longint'(hh);
        end
        if (cv > 0) begin
            upd = sat_value(a1 + step);
            res = (upd < cv) ? upd : cv;
        end else begin
            upd = sat_value(a2 - step);
            res = (upd > cv) ? upd : cv;
        end
        return t_value'(res);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_value rand_value();
        return t_value'($urandom);
    endfunction

    function automatic t_value extreme_value();
        case ($urandom_range(0, 5))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '0;
            3: return t_value'(1);
            4: return t_value'(-1);
            default: return rand_value();
        endcase
    endfunction

    function automatic t_value near_value(longint anchor, longint unsigned span);
        longint unsigned r;
        r = {$urandom, $urandom};
        return t_value'(sat_value(anchor + longint'(r % (2 * span + 1)) - longint'(span)));
    endfunction

    function automatic t_cell cell_of(t_value c, t_value w, t_value e, t_value s, t_value n,
                                      logic f);
        t_cell built;
        built.center = c;
        built.west   = w;
        built.east   = e;
        built.south  = s;
        built.north  = n;
        built.fixed  = f;
        return built;
    endfunction

    // Most cells look like a real sweep: neighbors and center within two spacings
    // of a shared anchor, so the quadratic branch is taken often.
    function automatic t_cell make_random_cell(t_spacing h);
        t_cell c;
        longint anchor;
        longint unsigned span;
        int kind;
        kind = $urandom_range(0, 99);
        span = 2 * longint'(h);
        if (kind < 15) begin
            c = cell_of(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(), 0);
        end else if (kind < 25) begin
            c = cell_of(extreme_value(), extreme_value(), extreme_value(), extreme_value(),
                        extreme_value(), 0);
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                anchor = longint'(rand_value());
            end else begin
                anchor = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
            c = cell_of(near_value(anchor, span), near_value(anchor, span),
                        near_value(anchor, span), near_value(anchor, span),
                        near_value(anchor, span), 0);
        end
        c.fixed = ($urandom_range(0, 9) == 0);
        return c;
    endfunction

    // ---------------------------------------------------------------- channel tasks

    task automatic send_cell(t_cell c);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        center_value <= c.center;
        west_value   <= c.west;
        east_value   <= c.east;
        south_value  <= c.south;
        north_value  <= c.north;
        is_fixed     <= c.fixed;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        expected_values.push_back(predict_new_value(c, spacing_model));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spacing(t_spacing h);
        cfg_data  <= h;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        spacing_model = h;
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_MISMATCH_LINES) $display("%0t mismatch: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("new_value %h with no item pending", new_value));
            end else begin
                want_value = expected_values.pop_front();
                if (new_value !== want_value)
                    report_mismatch($sformatf("new_value %h, predicted %h", new_value,
                                              want_value));
            end
            stall_left = recv_idle ? $urandom_range(0, 15) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        out_stall <= (hold_left > 0) || (stall_left > 0);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Runs on the spacing left by reset.
    task automatic test_directed_cells();
        t_cell cells[$];
        cells.push_back(cell_of(5 * ONE, 0, ONE, 2 * ONE, 3 * ONE, 0));
        cells.push_back(cell_of(5 * ONE, ONE, ONE, ONE, ONE, 0));
        cells.push_back(cell_of(5 * ONE, 0, 0, ONE - 1, ONE - 1, 0));
        cells.push_back(cell_of(5 * ONE, 0, 0, ONE, ONE, 0));
        cells.push_back(cell_of(ONE / 4, 0, 0, 0, 0, 0));
        cells.push_back(cell_of(0, -ONE, -2 * ONE, -ONE, -3 * ONE, 0));
        cells.push_back(cell_of(-5 * ONE, -ONE, -ONE, -ONE, -ONE, 0));
        cells.push_back(cell_of(-5 * ONE, -ONE, -4 * ONE, -3 * ONE, -6 * ONE, 0));
        cells.push_back(cell_of(VALUE_MAX, VALUE_MAX - 10, VALUE_MAX, VALUE_MAX,
                                VALUE_MAX - 5, 0));
        cells.push_back(cell_of(VALUE_MIN, VALUE_MIN, VALUE_MIN + 3, VALUE_MIN, VALUE_MIN, 0));
        cells.push_back(cell_of(ONE, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, 0));
        cells.push_back(cell_of(-ONE, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, 0));
        cells.push_back(cell_of(rand_value(), rand_value(), rand_value(), rand_value(),
                                rand_value(), 1));
        cells.push_back(cell_of(VALUE_MIN, 0, 0, 0, 0, 1));
        cells.push_back(cell_of(VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, 1));
        cells.push_back(cell_of(1, 0, 0, 0, 0, 0));
        cells.push_back(cell_of(-1, 0, 0, 0, 0, 0));
        cells.push_back(cell_of(VALUE_MIN, rand_value(), rand_value(), rand_value(),
                                rand_value(), 0));
        cells.push_back(cell_of(VALUE_MAX, -ONE, -2 * ONE, VALUE_MIN, -ONE, 0));
        cells.push_back(cell_of(0, 0, 0, 0, 0, 0));
        foreach (cells[i]) send_cell(cells[i]);
        wait_idle();
    endtask

    // Smallest and largest spacing, and zero spacing where only the linear form applies.
    task automatic test_spacing_extremes();
        t_spacing corners[3];
        corners = '{t_spacing'(1), SPACING_MAX, t_spacing'(0)};
        foreach (corners[i]) begin
            write_spacing(corners[i]);
            repeat (20) send_cell(make_random_cell(spacing_model));
            wait_idle();
        end
    endtask

    task automatic test_random_stream();
        t_spacing h;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: h = eik_pkg::SPACING_RESET;
                1: h = t_spacing'($urandom_range(1 << 10, 1 << 20));
                2: h = t_spacing'($urandom_range(1, SPACING_MAX));
                3: h = t_spacing'(3);
                4: h = t_spacing'(1 << 20);
                default: h = t_spacing'($urandom_range(1 << 14, 1 << 18));
            endcase
            write_spacing(h);
            send_idle = p[0];
            recv_idle = (p >= 2);
            repeat (PHASE_ITEMS) send_cell(make_random_cell(spacing_model));
            wait_idle();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // The output is held for a long stretch while cells keep coming, so the
    // pipeline fills and has to push back on its input.
    task automatic test_output_hold();
        write_spacing(eik_pkg::SPACING_RESET);
        send_idle = 1'b0;
        hold_request = 400;
        repeat (80) send_cell(make_random_cell(spacing_model));
        send_idle = 1'b1;
        wait_idle();
    endtask

    // The sender stops until every pending result has come back, then resumes.
    task automatic test_drain_pause();
        repeat (20) send_cell(make_random_cell(spacing_model));
        wait_idle();
        repeat (20) send_cell(make_random_cell(spacing_model));
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cells();
        test_spacing_extremes();
        test_random_stream();
        test_output_hold();
        test_drain_pause();
        if (expected_values.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
